// File: src/voxel_geodesic_distance_bfs_core_macros.svh
// Assertion macros for the voxel distance walk block.
// Used by the top level; expects clk and arst_n in scope.
`ifndef VOXEL_GEODESIC_DISTANCE_BFS_CORE_MACROS_SVH
`define VOXEL_GEODESIC_DISTANCE_BFS_CORE_MACROS_SVH

// same-cycle implication
`define VGD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define VGD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/vgd_pkg.sv
// Shared types, codes and the neighbour offset table for the voxel walk.
// No dependencies.
package vgd_pkg;

	localparam int DIST_W  = 16;
	localparam int PADDR_W = 5;

	// actions
	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// result status
	localparam logic [1:0] ST_READ     = 2'd0;
	localparam logic [1:0] ST_WALK     = 2'd1;
	localparam logic [1:0] ST_SEED_OUT = 2'd2;

	// register indexes
	localparam logic [2:0] REG_DIM_X     = 3'd0;
	localparam logic [2:0] REG_DIM_Y     = 3'd1;
	localparam logic [2:0] REG_DIM_Z     = 3'd2;
	localparam logic [2:0] REG_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_FULL_CONN = 3'd4;

	// offset codes: 0 is minus one, 1 is zero, 2 is plus one
	localparam logic [1:0] OFS_NEG  = 2'd0;
	localparam logic [1:0] OFS_ZERO = 2'd1;
	localparam logic [1:0] OFS_POS  = 2'd2;

	localparam logic [4:0] NB_LAST = 5'd26;

	typedef struct packed {
		logic [5:0]  dim_x;
		logic [5:0]  dim_y;
		logic [5:0]  dim_z;
		logic [15:0] threshold;
		logic        full_connectivity;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [14:0] voxel_index;
		logic [15:0] voxel_value;
		logic [4:0]  seed_x;
		logic [4:0]  seed_y;
		logic [4:0]  seed_z;
	} req_t;

	typedef struct packed {
		logic               valid;
		logic signed [15:0] distance;
		logic [1:0]         status;
		logic [15:0]        reached_count;
	} res_t;

	// neighbour k of the 3x3x3 cube as {oz, oy, ox} offset codes
	function automatic logic [5:0] nb_code(input logic [4:0] k);
		logic [5:0] c;
		c = '0;
		for (int i = 0; i < 27; i++) begin
			if (5'(i) == k) c = {2'(i / 9), 2'((i / 3) % 3), 2'(i % 3)};
		end
		return c;
	endfunction

endpackage

// File: src/vgd_if.sv
// Request and response channel interfaces for the voxel walk block.
// Depends on nothing but plain logic types.
interface vgd_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [14:0] voxel_index;
	logic [15:0] voxel_value;
	logic [4:0]  seed_x;
	logic [4:0]  seed_y;
	logic [4:0]  seed_z;
	modport source(output valid, action, voxel_index, voxel_value, seed_x, seed_y, seed_z,
		input ready);
	modport sink(input valid, action, voxel_index, voxel_value, seed_x, seed_y, seed_z,
		output ready);
endinterface

interface vgd_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] distance;
	logic [1:0]         status;
	logic [15:0]        reached_count;
	modport source(output valid, distance, status, reached_count, input ready);
	modport sink(input valid, distance, status, reached_count, output ready);
endinterface

// File: src/vgd_cfg_regs.sv
// APB-style configuration registers of the voxel walk block.
// Depends on vgd_pkg.
module vgd_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vgd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output vgd_pkg::cfg_t               cfg
);
	vgd_pkg::cfg_t cfg_q;
	logic [2:0]    ridx;

	assign ridx   = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dim_x             <= 6'd32;
			cfg_q.dim_y             <= 6'd32;
			cfg_q.dim_z             <= 6'd32;
			cfg_q.threshold         <= 16'd1;
			cfg_q.full_connectivity <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				vgd_pkg::REG_DIM_X:     cfg_q.dim_x <= pwdata[5:0];
				vgd_pkg::REG_DIM_Y:     cfg_q.dim_y <= pwdata[5:0];
				vgd_pkg::REG_DIM_Z:     cfg_q.dim_z <= pwdata[5:0];
				vgd_pkg::REG_THRESHOLD: cfg_q.threshold <= pwdata[15:0];
				vgd_pkg::REG_FULL_CONN: cfg_q.full_connectivity <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read-back
	always_comb begin
		case (ridx)
			vgd_pkg::REG_DIM_X:     prdata = {26'd0, cfg_q.dim_x};
			vgd_pkg::REG_DIM_Y:     prdata = {26'd0, cfg_q.dim_y};
			vgd_pkg::REG_DIM_Z:     prdata = {26'd0, cfg_q.dim_z};
			vgd_pkg::REG_THRESHOLD: prdata = {16'd0, cfg_q.threshold};
			vgd_pkg::REG_FULL_CONN: prdata = {31'd0, cfg_q.full_connectivity};
			default:                prdata = 32'd0;
		endcase
	end
endmodule

// File: src/vgd_walk_ctrl.sv
// Sequencer, distance store and frontier queue of the voxel walk block.
// Depends on vgd_pkg.
module vgd_walk_ctrl #(
	parameter int MAX_DIM_X       = 32,
	parameter int MAX_DIM_Y       = 32,
	parameter int MAX_DIM_Z       = 32,
	parameter int UNREACHED_VALUE = 32767
) (
	input  logic          clk,
	input  logic          arst_n,
	input  vgd_pkg::cfg_t cfg,
	input  logic          in_valid,
	output logic          in_ready,
	input  vgd_pkg::req_t req,
	output vgd_pkg::res_t res,
	input  logic          res_free
);
	localparam int VOL = MAX_DIM_X * MAX_DIM_Y * MAX_DIM_Z;
	localparam int AW  = $clog2(VOL);
	localparam int TW  = AW + 1;
	localparam int XW  = $clog2(MAX_DIM_X);
	localparam int YW  = $clog2(MAX_DIM_Y);
	localparam int ZW  = $clog2(MAX_DIM_Z);
	localparam int XDW = $clog2(MAX_DIM_X + 1);
	localparam int YDW = $clog2(MAX_DIM_Y + 1);
	localparam int ZDW = $clog2(MAX_DIM_Z + 1);
	localparam int FW  = AW + XW + YW + ZW;
	localparam logic [15:0] UNR16   = 16'(UNREACHED_VALUE);
	localparam logic [15:0] OUTSIDE = 16'hFFFF;

	localparam logic [4:0] S_IDLE    = 5'd0;
	localparam logic [4:0] S_MUL1    = 5'd1;
	localparam logic [4:0] S_MUL2    = 5'd2;
	localparam logic [4:0] S_MUL3    = 5'd3;
	localparam logic [4:0] S_EXEC    = 5'd4;
	localparam logic [4:0] S_RDOUT   = 5'd5;
	localparam logic [4:0] S_RESTORE = 5'd6;
	localparam logic [4:0] S_SWEEP   = 5'd7;
	localparam logic [4:0] S_SEEDRD  = 5'd8;
	localparam logic [4:0] S_SEEDSET = 5'd9;
	localparam logic [4:0] S_POP     = 5'd10;
	localparam logic [4:0] S_PDIST   = 5'd11;
	localparam logic [4:0] S_PCALC   = 5'd12;
	localparam logic [4:0] S_NBRD    = 5'd13;
	localparam logic [4:0] S_NBCK    = 5'd14;
	localparam logic [4:0] S_DONE    = 5'd15;

	logic [4:0]     state_q;
	vgd_pkg::req_t  req_q;
	logic [TW-1:0]  plane_q, total_q, cnt_q, head_q, tail_q;
	logic [AW-1:0]  ysum_q, seed_q, seed_idx_q, swa_s1, p_q, q_q;
	logic           seed_out_q, swv_s1, rd_in_q;
	logic [15:0]    reached_q;
	logic [XW-1:0]  px_q, qx_q;
	logic [YW-1:0]  py_q, qy_q;
	logic [ZW-1:0]  pz_q, qz_q;
	logic [16:0]    nd_q;
	logic [4:0]     k_q;

	// effective dimensions
	logic [XDW-1:0] nx;
	logic [YDW-1:0] ny;
	logic [ZDW-1:0] nz;
	assign nx = (cfg.dim_x == 6'd0) ? XDW'(1) :
		(32'(cfg.dim_x) > 32'(MAX_DIM_X)) ? XDW'(MAX_DIM_X) : XDW'(cfg.dim_x);
	assign ny = (cfg.dim_y == 6'd0) ? YDW'(1) :
		(32'(cfg.dim_y) > 32'(MAX_DIM_Y)) ? YDW'(MAX_DIM_Y) : YDW'(cfg.dim_y);
	assign nz = (cfg.dim_z == 6'd0) ? ZDW'(1) :
		(32'(cfg.dim_z) > 32'(MAX_DIM_Z)) ? ZDW'(MAX_DIM_Z) : ZDW'(cfg.dim_z);

	// distance store and frontier queue
	logic [15:0]   dmem [VOL];
	logic [FW-1:0] fmem [VOL];
	logic          dwe, fwe;
	logic [AW-1:0] dwa, dra, fwa, fra;
	logic [15:0]   dwd, drd;
	logic [FW-1:0] fwd, frd;

	always_ff @(posedge clk) begin
		if (dwe) dmem[dwa] <= dwd;
		drd <= dmem[dra];
	end

	always_ff @(posedge clk) begin
		if (fwe) fmem[fwa] <= fwd;
		frd <= fmem[fra];
	end

	logic [AW-1:0] f_p;
	logic [XW-1:0] f_x;
	logic [YW-1:0] f_y;
	logic [ZW-1:0] f_z;
	assign {f_p, f_x, f_y, f_z} = frd;

	// item decode
	logic idx_in, seed_bad;
	assign idx_in   = 32'(req_q.voxel_index) < 32'(total_q);
	assign seed_bad = (32'(req_q.seed_x) >= 32'(nx)) || (32'(req_q.seed_y) >= 32'(ny)) ||
		(32'(req_q.seed_z) >= 32'(nz));

	// neighbour decode for the current offset
	logic [5:0]    code;
	logic [1:0]    ox, oy, oz, manh;
	logic          xok, yok, zok, nb_ok;
	logic [XW-1:0] tx;
	logic [YW-1:0] ty;
	logic [ZW-1:0] tz;
	logic [AW-1:0] xoff, yoff, zoff, qn;

	always_comb begin
		code = vgd_pkg::nb_code(k_q);
		{oz, oy, ox} = code;
		manh = 2'(ox != vgd_pkg::OFS_ZERO) + 2'(oy != vgd_pkg::OFS_ZERO) +
			2'(oz != vgd_pkg::OFS_ZERO);
		xok = (ox == vgd_pkg::OFS_ZERO) ||
			((ox == vgd_pkg::OFS_NEG) && (px_q != '0)) ||
			((ox == vgd_pkg::OFS_POS) && (32'(px_q) + 32'd1 < 32'(nx)));
		yok = (oy == vgd_pkg::OFS_ZERO) ||
			((oy == vgd_pkg::OFS_NEG) && (py_q != '0)) ||
			((oy == vgd_pkg::OFS_POS) && (32'(py_q) + 32'd1 < 32'(ny)));
		zok = (oz == vgd_pkg::OFS_ZERO) ||
			((oz == vgd_pkg::OFS_NEG) && (pz_q != '0)) ||
			((oz == vgd_pkg::OFS_POS) && (32'(pz_q) + 32'd1 < 32'(nz)));
		nb_ok = (manh != 2'd0) && (cfg.full_connectivity || (manh == 2'd1)) &&
			xok && yok && zok;
		tx = (ox == vgd_pkg::OFS_NEG) ? px_q - XW'(1) :
			(ox == vgd_pkg::OFS_POS) ? px_q + XW'(1) : px_q;
		ty = (oy == vgd_pkg::OFS_NEG) ? py_q - YW'(1) :
			(oy == vgd_pkg::OFS_POS) ? py_q + YW'(1) : py_q;
		tz = (oz == vgd_pkg::OFS_NEG) ? pz_q - ZW'(1) :
			(oz == vgd_pkg::OFS_POS) ? pz_q + ZW'(1) : pz_q;
		// linear neighbour address, modulo the address width
		xoff = (ox == vgd_pkg::OFS_NEG) ? {AW{1'b1}} :
			(ox == vgd_pkg::OFS_POS) ? AW'(1) : '0;
		yoff = (oy == vgd_pkg::OFS_NEG) ? AW'(0) - AW'(nx) :
			(oy == vgd_pkg::OFS_POS) ? AW'(nx) : '0;
		zoff = (oz == vgd_pkg::OFS_NEG) ? AW'(0) - AW'(plane_q) :
			(oz == vgd_pkg::OFS_POS) ? AW'(plane_q) : '0;
		qn = p_q + xoff + yoff + zoff;
	end

	logic nb_hit, q_room;
	assign nb_hit = (drd == UNR16) && (32'(nd_q) < 32'(UNREACHED_VALUE));
	assign q_room = 32'(tail_q) < 32'(VOL);

	// memory port drive per state
	always_comb begin
		dwe = 1'b0;
		dwa = '0;
		dwd = '0;
		dra = '0;
		fwe = 1'b0;
		fwa = '0;
		fwd = '0;
		fra = '0;
		case (state_q)
			S_EXEC: begin
				dra = AW'(req_q.voxel_index);
				if (req_q.action == vgd_pkg::ACT_LOAD && idx_in) begin
					dwe = 1'b1;
					dwa = AW'(req_q.voxel_index);
					dwd = (req_q.voxel_value >= cfg.threshold) ? UNR16 : OUTSIDE;
				end
			end
			S_RDOUT: dra = AW'(req_q.voxel_index);
			S_RESTORE: begin
				dwe = seed_out_q;
				dwa = seed_idx_q;
				dwd = OUTSIDE;
			end
			S_SWEEP: begin
				dra = AW'(cnt_q);
				dwe = swv_s1 && !drd[15];
				dwa = swa_s1;
				dwd = UNR16;
			end
			S_SEEDRD: dra = seed_q;
			S_SEEDSET: begin
				dwe = 1'b1;
				dwa = seed_q;
				dwd = '0;
				fwe = 1'b1;
				fwa = '0;
				fwd = {seed_q, XW'(req_q.seed_x), YW'(req_q.seed_y), ZW'(req_q.seed_z)};
			end
			S_POP:   fra = AW'(head_q);
			S_PDIST: dra = f_p;
			S_NBRD:  dra = qn;
			S_NBCK: begin
				dwe = nb_hit;
				dwa = q_q;
				dwd = nd_q[15:0];
				fwe = nb_hit && q_room;
				fwa = AW'(tail_q);
				fwd = {q_q, qx_q, qy_q, qz_q};
			end
			default: ;
		endcase
	end

	// result beat
	always_comb begin
		res.valid         = 1'b0;
		res.distance      = '0;
		res.status        = vgd_pkg::ST_READ;
		res.reached_count = reached_q;
		case (state_q)
			S_EXEC: begin
				res.valid  = (req_q.action == vgd_pkg::ACT_START) && seed_bad && res_free;
				res.status = vgd_pkg::ST_SEED_OUT;
			end
			S_RDOUT: begin
				res.valid    = res_free;
				res.distance = rd_in_q ? $signed(drd) : $signed(OUTSIDE);
			end
			S_DONE: begin
				res.valid  = res_free;
				res.status = vgd_pkg::ST_WALK;
			end
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			req_q      <= '0;
			plane_q    <= '0;
			total_q    <= '0;
			ysum_q     <= '0;
			seed_q     <= '0;
			seed_out_q <= 1'b0;
			seed_idx_q <= '0;
			reached_q  <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			cnt_q      <= '0;
			swv_s1     <= 1'b0;
			swa_s1     <= '0;
			rd_in_q    <= 1'b0;
			p_q        <= '0;
			px_q       <= '0;
			py_q       <= '0;
			pz_q       <= '0;
			q_q        <= '0;
			qx_q       <= '0;
			qy_q       <= '0;
			qz_q       <= '0;
			nd_q       <= '0;
			k_q        <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q   <= req;
						state_q <= S_MUL1;
					end
				end
				// volume sizes and seed address, computed over the multiply states
				S_MUL1: begin
					plane_q <= TW'(nx) * TW'(ny);
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					total_q <= plane_q * TW'(nz);
					ysum_q  <= AW'(nx) * AW'(req_q.seed_y);
					state_q <= S_MUL3;
				end
				S_MUL3: begin
					seed_q  <= AW'(req_q.seed_x) + ysum_q +
						AW'(plane_q * TW'(req_q.seed_z));
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					case (req_q.action)
						vgd_pkg::ACT_LOAD: begin
							if (idx_in && seed_out_q &&
								seed_idx_q == AW'(req_q.voxel_index)) begin
								seed_out_q <= 1'b0;
							end
							state_q <= S_IDLE;
						end
						vgd_pkg::ACT_READ: begin
							rd_in_q <= idx_in;
							state_q <= S_RDOUT;
						end
						vgd_pkg::ACT_START: begin
							if (!seed_bad) state_q <= S_RESTORE;
							else if (res_free) state_q <= S_IDLE;
						end
						default: state_q <= S_IDLE;
					endcase
				end
				S_RDOUT: begin
					if (res_free) state_q <= S_IDLE;
				end
				S_RESTORE: begin
					seed_out_q <= 1'b0;
					cnt_q      <= '0;
					swv_s1     <= 1'b0;
					state_q    <= S_SWEEP;
				end
				// re-arm inside voxels: read one, write back the previous
				S_SWEEP: begin
					if (cnt_q < total_q) begin
						swv_s1 <= 1'b1;
						swa_s1 <= AW'(cnt_q);
						cnt_q  <= cnt_q + TW'(1);
					end else begin
						swv_s1 <= 1'b0;
						if (!swv_s1) state_q <= S_SEEDRD;
					end
				end
				S_SEEDRD: state_q <= S_SEEDSET;
				S_SEEDSET: begin
					if (drd[15]) begin
						seed_out_q <= 1'b1;
						seed_idx_q <= seed_q;
					end
					reached_q <= 16'd1;
					head_q    <= '0;
					tail_q    <= TW'(1);
					state_q   <= S_POP;
				end
				S_POP: begin
					if (head_q == tail_q || 32'(head_q) >= 32'(VOL)) begin
						state_q <= S_DONE;
					end else begin
						head_q  <= head_q + TW'(1);
						state_q <= S_PDIST;
					end
				end
				S_PDIST: begin
					p_q     <= f_p;
					px_q    <= f_x;
					py_q    <= f_y;
					pz_q    <= f_z;
					state_q <= S_PCALC;
				end
				S_PCALC: begin
					nd_q    <= 17'(drd) + 17'd1;
					k_q     <= '0;
					state_q <= S_NBRD;
				end
				S_NBRD: begin
					if (nb_ok) begin
						q_q     <= qn;
						qx_q    <= tx;
						qy_q    <= ty;
						qz_q    <= tz;
						state_q <= S_NBCK;
					end else if (k_q == vgd_pkg::NB_LAST) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 5'd1;
					end
				end
				S_NBCK: begin
					if (nb_hit) begin
						reached_q <= reached_q + 16'd1;
						if (q_room) tail_q <= tail_q + TW'(1);
					end
					if (k_q == vgd_pkg::NB_LAST) begin
						state_q <= S_POP;
					end else begin
						k_q     <= k_q + 5'd1;
						state_q <= S_NBRD;
					end
				end
				S_DONE: begin
					if (res_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: src/voxel_geodesic_distance_bfs_core.sv
// Top level of the breadth-first voxel distance block: config port,
// sequencer and output register. Depends on vgd_pkg, vgd_if, vgd_cfg_regs, vgd_walk_ctrl.
//
// Usage: items arrive on req (valid/ready); a beat is taken when both are high.
// action 0 loads one voxel, classified against the threshold in force; no result.
// action 1 starts a walk from the seed and returns one result beat (status 1,
// reached_count), or status 2 at once when the seed lies outside the volume.
// action 2 reads one stored distance (status 0). Results leave on rsp through
// an output register, so the sequencer can finish while a beat waits.
// Steps: a load passes the multiply states, then writes the store; a read passes the
// multiply states and a store read before its result enters the output register. A
// walk re-arms every inside voxel, then for each dequeued voxel reads its entry and
// distance and steps every offset code whatever the connectivity, with an extra check
// state for each enabled neighbour in bounds.
// req.ready is high only while the sequencer is idle: one item at a time.
// Reset clears the sequencer and registers; stored distances are undefined until loaded.
// A stalled rsp holds its beat and the sequencer waits before the next one. Configuration
// goes through the APB-style port, written only while idle: a user duty, unchecked here.
`include "voxel_geodesic_distance_bfs_core_macros.svh"

module voxel_geodesic_distance_bfs_core #(
	parameter int MAX_DIM_X       = 32,
	parameter int MAX_DIM_Y       = 32,
	parameter int MAX_DIM_Z       = 32,
	parameter int UNREACHED_VALUE = 32767
) (
	input  logic                        clk,
	input  logic                        arst_n,
	vgd_req_if.sink                     req,
	vgd_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [vgd_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	vgd_pkg::cfg_t cfg;
	vgd_pkg::req_t req_w;
	vgd_pkg::res_t res;
	logic          res_free;
	logic          ov_q;
	logic signed [15:0] dist_q;
	logic [1:0]    status_q;
	logic [15:0]   count_q;

	vgd_cfg_regs u_cfg (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	assign req_w.action      = req.action;
	assign req_w.voxel_index = req.voxel_index;
	assign req_w.voxel_value = req.voxel_value;
	assign req_w.seed_x      = req.seed_x;
	assign req_w.seed_y      = req.seed_y;
	assign req_w.seed_z      = req.seed_z;

	vgd_walk_ctrl #(
		.MAX_DIM_X(MAX_DIM_X), .MAX_DIM_Y(MAX_DIM_Y), .MAX_DIM_Z(MAX_DIM_Z),
		.UNREACHED_VALUE(UNREACHED_VALUE)
	) u_ctrl (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_valid(req.valid), .in_ready(req.ready),
		.req(req_w), .res(res), .res_free(res_free)
	);

	// output register
	assign res_free = !ov_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q     <= 1'b0;
			dist_q   <= '0;
			status_q <= '0;
			count_q  <= '0;
		end else if (res.valid) begin
			ov_q     <= 1'b1;
			dist_q   <= res.distance;
			status_q <= res.status;
			count_q  <= res.reached_count;
		end else if (rsp.ready) begin
			ov_q <= 1'b0;
		end
	end

	assign rsp.valid         = ov_q;
	assign rsp.distance      = dist_q;
	assign rsp.status        = status_q;
	assign rsp.reached_count = count_q;

	// checks
	`VGD_ASSERT_NOW(a_res_fits, res.valid, res_free, "result beat produced while output full")
	`VGD_ASSERT_NEXT(a_busy_after_take, req.valid && req.ready, !req.ready,
		"request taken while an item is in work")
	`VGD_ASSERT_NOW(a_seed_out_zero, rsp.valid && (rsp.status == vgd_pkg::ST_SEED_OUT),
		rsp.distance == 16'sd0, "ignored seed must report zero distance")
endmodule
